// ===== sv/fspa_pkg.sv =====
// Shared constants and types of the fixed slot pool allocator.
package fspa_pkg;

  localparam int POOL_DEPTH_DEF   = 64;
  localparam int OBJECT_BYTES_DEF = 64;

  localparam int ADDR_W    = 48;
  localparam int STATUS_W  = 2;
  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_EMPTY        = 2'd1,
    STATUS_NOT_OWNED    = 2'd2,
    STATUS_ALREADY_FREE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ACQ,
    S_REL,
    S_REJECT
  } state_e;

endpackage

// ===== sv/fspa_if.sv =====
// Request and response channel interfaces of the pool allocator.
interface fspa_req_if
  import fspa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] slot_address;

  modport source (output valid, output mode, output slot_address, input ready);
  modport sink   (input valid, input mode, input slot_address, output ready);
endinterface

interface fspa_rsp_if
  import fspa_pkg::*;
();
  logic                 valid;
  logic                 ready;
  status_e              status;
  logic [ADDR_W-1:0]    granted_address;
  logic [IDX_OUT_W-1:0] slot_index;
  logic [CNT_OUT_W-1:0] free_count;

  modport source (output valid, output status, output granted_address,
                  output slot_index, output free_count, input ready);
  modport sink   (input valid, input status, input granted_address,
                  input slot_index, input free_count, output ready);
endinterface

// ===== sv/fixed_slot_pool_allocator.sv =====
// Top level of the fixed slot pool allocator: control FSM, free stack and in-use map.
//
// Usage: req_i carries one transaction per request: mode 0 acquires a slot, mode 1
// releases the slot at slot_address. rsp_o returns exactly one transaction per
// request with status, granted_address, slot_index and free_count. base_address
// is written through cfg_we_i/cfg_wdata_i; the user must write it only while the
// block is idle, which the block itself does not enforce.
// Timing: a request is taken in the idle state; its response is loaded into the
// output register from S_ACQ, S_REL or S_REJECT once the output is free, and the
// next request is taken only back in idle. With a non power-of-two OBJECT_BYTES
// a release that passes the range check first runs the reciprocal slot divide
// and exactness check in S_DIV. The rate is set by the read-modify-write of the
// free stack and in-use map RAMs (registered read, write in the final state).
// Reset: the stack and map RAMs are not cleared. A low watermark of the stack
// count marks which stack entries and map entries were ever written; unwritten
// ones read as their reset value, so the block is ready right after reset.
// Stall: while rsp_o is held off, a finished result waits in the output register
// and a new request is still taken; it finishes only once the output frees up.
module fixed_slot_pool_allocator
  import fspa_pkg::*;
#(
  parameter int POOL_DEPTH   = POOL_DEPTH_DEF,
  parameter int OBJECT_BYTES = OBJECT_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fspa_req_if.sink          req_i,
  fspa_rsp_if.source        rsp_o,
  input  logic              cfg_we_i,
  input  logic [ADDR_W-1:0] cfg_wdata_i
);

  localparam int IDX_W   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
  localparam int CW1     = CNT_W + 1;
  localparam int OBJ_W   = $clog2(OBJECT_BYTES + 1);
  localparam int OBJ_SH  = $clog2(OBJECT_BYTES);
  localparam bit IS_POW2 = ((1 << OBJ_SH) == OBJECT_BYTES);
  localparam int LIMIT   = POOL_DEPTH * OBJECT_BYTES;
  localparam int OFF_W   = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam int PROD_W  = IDX_W + OBJ_W;
  localparam int RCP_SH  = OFF_W + OBJ_SH;
  localparam int RCP_W   = OFF_W + 1;
  localparam int RPROD_W = OFF_W + RCP_W;

  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(POOL_DEPTH);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(POOL_DEPTH - 1);
  localparam logic [OBJ_W-1:0]  OBJ_C    = OBJ_W'(OBJECT_BYTES);
  // rounded-up reciprocal, exact quotient for every offset below 2**OFF_W
  localparam logic [RCP_W-1:0]  RCP_C    =
    RCP_W'(((64'd1 << RCP_SH) + 64'(OBJECT_BYTES) - 64'd1) / 64'(OBJECT_BYTES));

  // an entry was written once the watermark fell to its stack position
  function automatic logic map_written(input logic [IDX_W-1:0] s,
                                       input logic [CNT_W-1:0] wm);
    logic [CW1-1:0] sum;
    sum = CW1'(s) + CW1'(wm);
    return sum < CW1'(POOL_DEPTH);
  endfunction

  state_e state_q, state_d;

  logic [ADDR_W-1:0]  base_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   wm_q, wm_d;
  status_e            rej_q, rej_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic               vld_q, vld_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic [IDX_W-1:0]   quo_q, quo_d, div_quo;
  logic               dph_q, dph_d;
  logic [RPROD_W-1:0] rcp_prod;
  logic [PROD_W-1:0]  div_back;
  logic               div_exact;

  logic                 ovalid_q, ovalid_d;
  status_e              ost_q, ost_d;
  logic [ADDR_W-1:0]    oaddr_q, oaddr_d;
  logic [IDX_OUT_W-1:0] oidx_q, oidx_d;
  logic [CNT_OUT_W-1:0] ocnt_q, ocnt_d;

  // free stack and in-use map RAM ports
  logic             stk_re, stk_we;
  logic [IDX_W-1:0] stk_raddr, stk_waddr, stk_wdata, stk_rdata;
  logic             map_re, map_we, map_wdata, map_rdata;
  logic [IDX_W-1:0] map_raddr, map_waddr;

  logic              ac_bad, ac_mis;
  logic [OFF_W-1:0]  ac_off;
  logic [IDX_W-1:0]  ac_slot;

  logic              req_fire, out_free, out_load, in_use;
  logic [CNT_W-1:0]  cnt_dec;
  logic [IDX_W-1:0]  stk_top, acq_slot;
  logic [PROD_W-1:0] acq_prod;

  fspa_ram #(.DEPTH(POOL_DEPTH), .WIDTH(IDX_W)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  fspa_ram #(.DEPTH(POOL_DEPTH), .WIDTH(1)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  fspa_addr_check #(.POOL_DEPTH(POOL_DEPTH), .OBJECT_BYTES(OBJECT_BYTES)) u_addr_check (
    .addr_i     (req_i.slot_address),
    .base_i     (base_q),
    .bad_o      (ac_bad),
    .off_o      (ac_off),
    .slot_o     (ac_slot),
    .misalign_o (ac_mis)
  );

  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !ovalid_q || rsp_o.ready;
  assign cnt_dec  = cnt_q - 1'b1;
  assign stk_top  = cnt_dec[IDX_W-1:0];

  // unwritten stack positions hold POOL_DEPTH-1 minus the position
  assign acq_slot = vld_q ? stk_rdata : (IDX_LAST - slot_q);
  assign acq_prod = PROD_W'(acq_slot) * PROD_W'(OBJ_C);
  assign in_use   = vld_q && map_rdata;

  // reciprocal division: quotient while dph_q is low, exactness check while dph_q is high
  assign rcp_prod  = RPROD_W'(off_q) * RPROD_W'(RCP_C);
  assign div_quo   = IDX_W'(rcp_prod >> RCP_SH);
  assign div_back  = PROD_W'(quo_q) * PROD_W'(OBJ_C);
  assign div_exact = (div_back == PROD_W'(off_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (!req_i.mode) begin
            state_d = (cnt_q == '0) ? S_REJECT : S_ACQ;
          end else if (ac_bad) begin
            state_d = S_REJECT;
          end else if (IS_POW2) begin
            state_d = ac_mis ? S_REJECT : S_REL;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (dph_q) begin
          state_d = div_exact ? S_REL : S_REJECT;
        end
      end
      S_ACQ, S_REL, S_REJECT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath, RAM controls and result
  always_comb begin
    cnt_d     = cnt_q;
    wm_d      = wm_q;
    rej_d     = rej_q;
    slot_d    = slot_q;
    vld_d     = vld_q;
    off_d     = off_q;
    quo_d     = quo_q;
    dph_d     = dph_q;
    stk_re    = 1'b0;
    stk_raddr = stk_top;
    stk_we    = 1'b0;
    stk_waddr = cnt_q[IDX_W-1:0];
    stk_wdata = slot_q;
    map_re    = 1'b0;
    map_raddr = ac_slot;
    map_we    = 1'b0;
    map_waddr = slot_q;
    map_wdata = 1'b0;
    out_load  = 1'b0;
    ost_d     = STATUS_OK;
    oaddr_d   = '0;
    oidx_d    = '0;
    ocnt_d    = CNT_OUT_W'(cnt_q);

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (!req_i.mode) begin
            rej_d  = STATUS_EMPTY;
            slot_d = stk_top;
            vld_d  = (cnt_dec >= wm_q);
            stk_re = (cnt_q != '0);
          end else begin
            rej_d  = STATUS_NOT_OWNED;
            off_d  = ac_off;
            dph_d  = 1'b0;
            if (IS_POW2) begin
              slot_d = ac_slot;
              vld_d  = map_written(ac_slot, wm_q);
              map_re = !ac_bad && !ac_mis;
            end
          end
        end
      end
      S_DIV: begin
        dph_d = 1'b1;
        if (!dph_q) begin
          quo_d = div_quo;
        end else if (div_exact) begin
          slot_d    = quo_q;
          vld_d     = map_written(quo_q, wm_q);
          map_re    = 1'b1;
          map_raddr = quo_q;
        end
      end
      S_ACQ: begin
        if (out_free) begin
          cnt_d     = cnt_dec;
          if (cnt_dec < wm_q) begin
            wm_d = cnt_dec;
          end
          map_we    = 1'b1;
          map_waddr = acq_slot;
          map_wdata = 1'b1;
          out_load  = 1'b1;
          oaddr_d   = base_q + ADDR_W'(acq_prod);
          oidx_d    = IDX_OUT_W'(acq_slot);
          ocnt_d    = CNT_OUT_W'(cnt_dec);
        end
      end
      S_REL: begin
        if (out_free) begin
          out_load = 1'b1;
          oidx_d   = IDX_OUT_W'(slot_q);
          if (in_use) begin
            map_we = 1'b1;
            if (cnt_q < CNT_FULL) begin
              stk_we = 1'b1;
              cnt_d  = cnt_q + 1'b1;
            end
            ocnt_d = CNT_OUT_W'(cnt_d);
          end else begin
            ost_d = STATUS_ALREADY_FREE;
          end
        end
      end
      S_REJECT: begin
        if (out_free) begin
          out_load = 1'b1;
          ost_d    = rej_q;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      ovalid_d = 1'b1;
    end else begin
      ovalid_d = ovalid_q && !rsp_o.ready;
    end
  end

  assign req_i.ready           = (state_q == S_IDLE);
  assign rsp_o.valid           = ovalid_q;
  assign rsp_o.status          = ost_q;
  assign rsp_o.granted_address = oaddr_q;
  assign rsp_o.slot_index      = oidx_q;
  assign rsp_o.free_count      = ocnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      base_q   <= '0;
      cnt_q    <= CNT_FULL;
      wm_q     <= CNT_FULL;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      wm_q     <= wm_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rej_q  <= rej_d;
    slot_q <= slot_d;
    vld_q  <= vld_d;
    off_q  <= off_d;
    quo_q  <= quo_d;
    dph_q  <= dph_d;
    if (out_load) begin
      ost_q   <= ost_d;
      oaddr_q <= oaddr_d;
      oidx_q  <= oidx_d;
      ocnt_q  <= ocnt_d;
    end
  end

  // watermark never above the live stack count
  a_wm_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wm_q <= cnt_q)
    else $error("watermark above stack count");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("stack count past pool depth");

  // a completed acquire pops exactly one entry
  a_acq_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACQ) && out_free |=> cnt_q == CNT_W'($past(cnt_q) - 1'b1))
    else $error("acquire did not pop one entry");

  // a release only clears a map entry that read back as in use
  a_rel_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REL) && map_we |-> vld_q && map_rdata)
    else $error("release cleared a slot not in use");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != STATUS_OK) |-> rsp_o.granted_address == '0)
    else $error("error response with nonzero address");

endmodule

// ===== sv/fspa_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
module fspa_ram
  import fspa_pkg::*;
#(
  parameter int DEPTH = POOL_DEPTH_DEF,
  parameter int WIDTH = 1,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/fspa_addr_check.sv =====
// Release address check: null, below base, past end; slot and alignment for power-of-two slots.
module fspa_addr_check
  import fspa_pkg::*;
#(
  parameter int POOL_DEPTH   = POOL_DEPTH_DEF,
  parameter int OBJECT_BYTES = OBJECT_BYTES_DEF,
  localparam int IDX_W  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
  localparam int LIMIT  = POOL_DEPTH * OBJECT_BYTES,
  localparam int OFF_W  = (LIMIT > 1) ? $clog2(LIMIT) : 1
) (
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [ADDR_W-1:0] base_i,
  output logic              bad_o,
  output logic [OFF_W-1:0]  off_o,
  output logic [IDX_W-1:0]  slot_o,
  output logic              misalign_o
);

  localparam int OBJ_SH  = $clog2(OBJECT_BYTES);
  localparam bit IS_POW2 = ((1 << OBJ_SH) == OBJECT_BYTES);
  localparam logic [ADDR_W-1:0] LIMIT_C  = ADDR_W'(LIMIT);
  localparam logic [ADDR_W-1:0] OBJ_MASK = ADDR_W'(OBJECT_BYTES - 1);

  logic [ADDR_W:0]   diff;
  logic [ADDR_W-1:0] off;

  // borrow out of the subtract flags an address below the base
  assign diff = {1'b0, addr_i} - {1'b0, base_i};
  assign off  = diff[ADDR_W-1:0];

  assign bad_o      = (addr_i == '0) || diff[ADDR_W] || (off >= LIMIT_C);
  assign off_o      = off[OFF_W-1:0];
  assign slot_o     = IDX_W'(off >> OBJ_SH);
  assign misalign_o = IS_POW2 && ((off & OBJ_MASK) != '0);

endmodule
